@@ hdl/gmm_pkg.sv @@
package gmm_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ID_BITS_DEF     = 12;
	localparam int SCORE_W         = 32;
	localparam int MATCH_W         = 7;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;

	localparam logic [SCORE_W-1:0]  MIN_SCORE_RST = SCORE_W'(1);
	localparam logic [ADDR_W-3:0]   REG_MIN_SCORE = '0;

	typedef struct packed {
		logic start;
		logic valid;
		logic live;
		logic kill_en;
	} scan_ctl_t;

endpackage

@@ hdl/gmm_table.sv @@
module gmm_table #(
	parameter int TABLE_DEPTH = gmm_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS     = gmm_pkg::ID_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [ID_BITS-1:0]          wr_inb,
	input  logic [ID_BITS-1:0]          wr_outb,
	input  logic [gmm_pkg::SCORE_W-1:0] wr_score,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output logic [ID_BITS-1:0]          rd_inb,
	output logic [ID_BITS-1:0]          rd_outb,
	output logic [gmm_pkg::SCORE_W-1:0] rd_score
);
	import gmm_pkg::*;

	localparam int EW = 2 * ID_BITS + SCORE_W;

	logic [EW-1:0] mem_q [TABLE_DEPTH];
	logic [EW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_inb, wr_outb, wr_score};
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_inb   = rd_data_q[EW-1 -: ID_BITS];
	assign rd_outb  = rd_data_q[SCORE_W + ID_BITS - 1 -: ID_BITS];
	assign rd_score = rd_data_q[SCORE_W-1:0];

endmodule

@@ hdl/gmm_best.sv @@
module gmm_best #(
	parameter int ID_BITS = gmm_pkg::ID_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gmm_pkg::scan_ctl_t          ctl,
	input  logic [ID_BITS-1:0]          inb,
	input  logic [ID_BITS-1:0]          outb,
	input  logic [gmm_pkg::SCORE_W-1:0] score,
	input  logic [ID_BITS-1:0]          kill_inb,
	input  logic [ID_BITS-1:0]          kill_outb,
	output logic                        kill,
	output logic                        found,
	output logic [ID_BITS-1:0]          best_inb,
	output logic [ID_BITS-1:0]          best_outb,
	output logic                        best_eq
);
	import gmm_pkg::*;

	logic               found_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [ID_BITS-1:0] best_inb_q;
	logic [ID_BITS-1:0] best_outb_q;
	logic               take;

	// entry shares an id with the pair just chosen
	assign kill = ctl.kill_en && (inb == kill_inb || outb == kill_outb);
	// strict compare keeps the lowest index on ties
	assign take = ctl.valid && ctl.live && !kill && (!found_q || score > best_score_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_score_q <= score;
			best_inb_q   <= inb;
			best_outb_q  <= outb;
		end
	end

	assign found     = found_q;
	assign best_inb  = best_inb_q;
	assign best_outb = best_outb_q;
	assign best_eq   = (best_inb_q == best_outb_q);

endmodule

@@ hdl/greedy_max_score_pair_matching.sv @@
// greedy max-score pair matcher
// request channel (item_valid/item_ready) carries one candidate pair per
// request: inbound_id, outbound_id, score and end_of_set. loading takes one
// request per cycle; pairs scoring below min_score are dropped, pairs beyond
// the table depth are dropped and flagged in overflowed.
// the end_of_set request starts matching and item_ready stays low until the
// run is done. each chosen pair costs one pass over the stored entries through
// the single table read port feeding the shared compare unit, then the wait and
// emit states; emit moves the previous pair to the output register and holds the
// new one as pending. a result is sent once the next pass shows whether it is
// the last one. an empty set gives one result with pair_valid low and
// last_result high. the result channel (result_valid/result_ready) has its own
// output register; when the receiver stalls the sequencer holds the next pair
// until it is free. reset clears the live flags and the counters and sets
// min_score to 1. min_score is written over the apb port (address 0), and the
// user must do so only while the block is idle; the block does not enforce it.
module greedy_max_score_pair_matching #(
	parameter int TABLE_DEPTH = gmm_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS     = gmm_pkg::ID_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gmm_pkg::ADDR_W-1:0]  paddr,
	input  logic [gmm_pkg::DATA_W-1:0]  pwdata,
	output logic [gmm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [ID_BITS-1:0]          inbound_id,
	input  logic [ID_BITS-1:0]          outbound_id,
	input  logic [gmm_pkg::SCORE_W-1:0] score,
	input  logic                        end_of_set,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        pair_valid,
	output logic [ID_BITS-1:0]          chosen_inbound,
	output logic [ID_BITS-1:0]          chosen_outbound,
	output logic                        ids_equal,
	output logic [gmm_pkg::MATCH_W-1:0] match_count,
	output logic                        overflowed,
	output logic                        last_result
);
	import gmm_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_WAIT,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	state_t                 state_q;
	logic [SCORE_W-1:0]     min_score_q;
	logic [CW-1:0]          count_q;
	logic                   ovf_q;
	logic [TABLE_DEPTH-1:0] live_q;
	logic [AW-1:0]          ra_q;
	logic                   valid_s1;
	logic [AW-1:0]          idx_s1;
	logic                   pend_q;
	logic [ID_BITS-1:0]     pend_inb_q;
	logic [ID_BITS-1:0]     pend_outb_q;
	logic                   pend_eq_q;
	logic [MATCH_W-1:0]     cnt_q;

	logic                   res_valid_q;
	logic                   pair_valid_q;
	logic [ID_BITS-1:0]     ch_inb_q;
	logic [ID_BITS-1:0]     ch_outb_q;
	logic                   eq_q;
	logic [MATCH_W-1:0]     mcnt_q;
	logic                   ovf_out_q;
	logic                   last_q;

	logic                   in_acc;
	logic                   wr_en;
	logic [AW-1:0]          last_addr;
	logic                   slot_free;
	logic                   adv;
	logic                   scan_go;
	logic                   cfg_wr;
	logic                   res_load;

	logic [ID_BITS-1:0]     rd_inb;
	logic [ID_BITS-1:0]     rd_outb;
	logic [SCORE_W-1:0]     rd_score;
	scan_ctl_t              ctl;
	logic                   kill;
	logic                   found;
	logic [ID_BITS-1:0]     best_inb;
	logic [ID_BITS-1:0]     best_outb;
	logic                   best_eq;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_MIN_SCORE);
	assign prdata = (paddr[ADDR_W-1:2] == REG_MIN_SCORE) ? min_score_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_score_q <= MIN_SCORE_RST;
		end else if (cfg_wr) begin
			min_score_q <= pwdata[SCORE_W-1:0];
		end
	end

	assign item_ready = (state_q == ST_LOAD);
	assign in_acc     = item_valid && item_ready;
	assign wr_en      = in_acc && (score >= min_score_q) && (count_q < CW'(TABLE_DEPTH));
	assign last_addr  = AW'(count_q - CW'(1));
	assign slot_free  = !res_valid_q || result_ready;
	assign adv        = !pend_q || slot_free;
	assign scan_go    = (in_acc && end_of_set && (wr_en || count_q != '0))
		|| (state_q == ST_EMIT && adv && found);
	assign res_load   = (state_q == ST_EMIT && adv && pend_q)
		|| (state_q == ST_EMPTY && slot_free);

	gmm_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_inb  (inbound_id),
		.wr_outb (outbound_id),
		.wr_score(score),
		.rd_addr (ra_q),
		.rd_inb  (rd_inb),
		.rd_outb (rd_outb),
		.rd_score(rd_score)
	);

	assign ctl.start   = scan_go;
	assign ctl.valid   = valid_s1;
	assign ctl.live    = live_q[idx_s1];
	assign ctl.kill_en = pend_q;

	gmm_best #(
		.ID_BITS(ID_BITS)
	) u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.inb      (rd_inb),
		.outb     (rd_outb),
		.score    (rd_score),
		.kill_inb (pend_inb_q),
		.kill_outb(pend_outb_q),
		.kill     (kill),
		.found    (found),
		.best_inb (best_inb),
		.best_outb(best_outb),
		.best_eq  (best_eq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			live_q       <= '0;
			ra_q         <= '0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			pend_q       <= 1'b0;
			pend_inb_q   <= '0;
			pend_outb_q  <= '0;
			pend_eq_q    <= 1'b0;
			cnt_q        <= '0;
			res_valid_q  <= 1'b0;
			pair_valid_q <= 1'b0;
			ch_inb_q     <= '0;
			ch_outb_q    <= '0;
			eq_q         <= 1'b0;
			mcnt_q       <= '0;
			ovf_out_q    <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			valid_s1 <= (state_q == ST_SCAN);
			idx_s1   <= ra_q;
			if (valid_s1 && kill) begin
				live_q[idx_s1] <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					ra_q <= '0;
					if (in_acc) begin
						if (wr_en) begin
							live_q[count_q[AW-1:0]] <= 1'b1;
							count_q <= count_q + CW'(1);
						end else if (score >= min_score_q) begin
							ovf_q <= 1'b1;
						end
						if (end_of_set) begin
							state_q <= scan_go ? ST_SCAN : ST_EMPTY;
						end
					end
				end
				ST_SCAN: begin
					ra_q <= ra_q + AW'(1);
					if (ra_q == last_addr) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (adv) begin
						if (pend_q) begin
							pair_valid_q <= 1'b1;
							ch_inb_q     <= pend_inb_q;
							ch_outb_q    <= pend_outb_q;
							eq_q         <= pend_eq_q;
							mcnt_q       <= cnt_q;
							ovf_out_q    <= ovf_q;
							last_q       <= !found;
						end
						if (found) begin
							pend_q      <= 1'b1;
							pend_inb_q  <= best_inb;
							pend_outb_q <= best_outb;
							pend_eq_q   <= best_eq;
							cnt_q       <= cnt_q + MATCH_W'(best_eq);
							ra_q        <= '0;
							state_q     <= ST_SCAN;
						end else begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							cnt_q   <= '0;
							pend_q  <= 1'b0;
							live_q  <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_EMPTY: begin
					if (slot_free) begin
						pair_valid_q <= 1'b0;
						ch_inb_q     <= '0;
						ch_outb_q    <= '0;
						eq_q         <= 1'b0;
						mcnt_q       <= '0;
						ovf_out_q    <= ovf_q;
						last_q       <= 1'b1;
						count_q      <= '0;
						ovf_q        <= 1'b0;
						live_q       <= '0;
						state_q      <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign result_valid    = res_valid_q;
	assign pair_valid      = pair_valid_q;
	assign chosen_inbound  = ch_inb_q;
	assign chosen_outbound = ch_outb_q;
	assign ids_equal       = eq_q;
	assign match_count     = mcnt_q;
	assign overflowed      = ovf_out_q;
	assign last_result     = last_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pair_valid |-> last_result)
		else $error("empty result not marked last");

	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> !pend_q && cnt_q == '0)
		else $error("run state left over while loading");

	a_ready_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_ready) |-> count_q == '0 && !ovf_q && live_q == '0)
		else $error("table not cleared at end of run");

endmodule
